>>> hw/rtl/zsre_pkg.sv
package zsre_pkg;

    // Default build sizes
    localparam int SAMPLE_BITS_DEF    = 10;
    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int MAX_ROWS_DEF       = 1024;

    // Largest supported sample width; words carry the sample in this field
    localparam int SAMPLE_W_MAX = 16;

    // Fixed field widths
    localparam int THRESHOLD_W = 10;
    localparam int CFG_LEN_W   = 11;
    localparam int RUN_OUT_W   = 11;
    localparam int WORD_IDX_W  = 20;

    // Configuration bus
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Register reset values
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST  = '0;
    localparam logic [CFG_LEN_W-1:0]   ROW_LENGTH_RST = 11'd1024;
    localparam logic [CFG_LEN_W-1:0]   ROW_COUNT_RST  = 11'd1024;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_ROW_LENGTH,
        REG_ROW_COUNT
    } reg_idx_t;

    // One result item
    typedef struct packed {
        logic                    is_run;
        logic [SAMPLE_W_MAX-1:0] sample_value;
        logic [RUN_OUT_W-1:0]    run_length;
        logic [WORD_IDX_W-1:0]   word_index;
        logic                    row_start;
        logic                    frame_end;
        logic                    last_for_item;
    } word_t;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hw/rtl/zsre_out_queue.sv
module zsre_out_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [1:0]              push_cnt,
    input  zsre_pkg::word_t         push_word0,
    input  zsre_pkg::word_t         push_word1,
    output logic                    room,
    output logic [zsre_pkg::Q_CNT_W-1:0] level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output zsre_pkg::word_t         out_word
);
    import zsre_pkg::*;

    word_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               pop;
    logic [Q_CNT_W-1:0] count_after_pop;

    assign pop             = (count_reg != '0) && out_ready;
    assign count_after_pop = count_reg - Q_CNT_W'(pop);
    // two free slots needed so an item with a run word and a kept word fits
    assign room            = count_after_pop <= Q_CNT_W'(Q_DEPTH - 2);
    assign out_valid       = count_reg != '0;
    assign out_word        = mem[rd_ptr_reg];
    assign level           = count_reg;

    // storage: up to two words written per cycle
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_word0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push_word1;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            count_reg  <= count_after_pop + Q_CNT_W'(push_cnt);
        end
    end

endmodule

>>> hw/rtl/zsre_encoder.sv
module zsre_encoder #(
    parameter int SAMPLE_BITS    = zsre_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_ROW_LENGTH = zsre_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = zsre_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            in_sample,
    input  logic [zsre_pkg::THRESHOLD_W-1:0]  threshold,
    input  logic [zsre_pkg::CFG_LEN_W-1:0]    row_length,
    input  logic [zsre_pkg::CFG_LEN_W-1:0]    row_count,
    input  logic                              room,
    output logic [1:0]                        push_cnt,
    output zsre_pkg::word_t                   push_word0,
    output zsre_pkg::word_t                   push_word1
);
    import zsre_pkg::*;

    localparam int CW   = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int RPW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW   = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CMPW = max_i(max_i(CFG_LEN_W, CW + 1),
                                max_i($clog2(MAX_ROW_LENGTH + 1), $clog2(MAX_ROWS + 1))) + 1;
    localparam int SW   = max_i(SAMPLE_BITS, THRESHOLD_W);

    // input stage
    logic                   stage_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    // encoder state
    logic [CW-1:0]         col_reg, col_next;
    logic [RPW-1:0]        row_reg, row_next;
    logic [RW-1:0]         run_reg, run_next, run_inc;
    logic [WORD_IDX_W-1:0] pos_reg, pos_next;
    logic                  has_word_reg, has_word_next;

    logic            fire;
    logic            suppress, row_end, frame_done;
    logic [CMPW-1:0] len_eff, cnt_eff;
    logic [1:0]      n_words;
    word_t           run_word, kept_word, word0, word1;

    assign fire     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (in_ready) begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= in_sample;
        end
    end

    // effective lengths: zero acts as one, above the build limit acts as the limit
    always_comb begin
        if (row_length == '0) begin
            len_eff = CMPW'(1);
        end else if (CMPW'(row_length) > CMPW'(MAX_ROW_LENGTH)) begin
            len_eff = CMPW'(MAX_ROW_LENGTH);
        end else begin
            len_eff = CMPW'(row_length);
        end
        if (row_count == '0) begin
            cnt_eff = CMPW'(1);
        end else if (CMPW'(row_count) > CMPW'(MAX_ROWS)) begin
            cnt_eff = CMPW'(MAX_ROWS);
        end else begin
            cnt_eff = CMPW'(row_count);
        end
    end

    assign suppress   = SW'(sample_reg) <= SW'(threshold);
    assign row_end    = (CMPW'(col_reg) + CMPW'(1)) >= len_eff;
    assign frame_done = row_end && ((CMPW'(row_reg) + CMPW'(1)) >= cnt_eff);
    assign run_inc    = run_reg + RW'(1);

    // word building
    always_comb begin
        run_word              = '0;
        run_word.is_run       = 1'b1;
        run_word.run_length   = suppress ? RUN_OUT_W'(run_inc) : RUN_OUT_W'(run_reg);
        kept_word             = '0;
        kept_word.sample_value = SAMPLE_W_MAX'(sample_reg);

        word0    = '0;
        word1    = '0;
        n_words  = 2'd0;
        run_next = run_reg;
        if (suppress) begin
            run_next = row_end ? '0 : run_inc;
            if (row_end) begin
                n_words = 2'd1;
                word0   = run_word;
            end
        end else begin
            run_next = '0;
            if (run_reg != '0) begin
                n_words = 2'd2;
                word0   = run_word;
                word1   = kept_word;
            end else begin
                n_words = 2'd1;
                word0   = kept_word;
            end
        end

        word0.word_index = pos_reg;
        word0.row_start  = !has_word_reg;
        word1.word_index = pos_reg + WORD_IDX_W'(1);
        word1.row_start  = 1'b0;

        // end marks go on the final word of the item
        if (n_words == 2'd1) begin
            word0.last_for_item = 1'b1;
            word0.frame_end     = frame_done;
        end
        if (n_words == 2'd2) begin
            word1.last_for_item = 1'b1;
            word1.frame_end     = frame_done;
        end
    end

    assign push_cnt   = fire ? n_words : 2'd0;
    assign push_word0 = word0;
    assign push_word1 = word1;

    // position bookkeeping
    always_comb begin
        pos_next      = pos_reg + WORD_IDX_W'(n_words);
        has_word_next = has_word_reg || (n_words != 2'd0);
        col_next      = col_reg + CW'(1);
        row_next      = row_reg;
        if (row_end) begin
            col_next      = '0;
            has_word_next = 1'b0;
            if (frame_done) begin
                row_next = '0;
                pos_next = '0;
            end else begin
                row_next = row_reg + RPW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            run_reg      <= '0;
            pos_reg      <= '0;
            has_word_reg <= 1'b0;
        end else if (fire) begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            run_reg      <= run_next;
            pos_reg      <= pos_next;
            has_word_reg <= has_word_next;
        end
    end

endmodule

>>> hw/rtl/zero_suppression_run_encoder_unit.sv
// Path: a sample is held in the input register, then its result items are written
//   to the result queue, whose head drives the m_ side; lack of queue room stalls it.
// Throughput: one sample per cycle while each sample gives at most one item and the
//   queue has room; a run flush plus a kept sample writes two items, sent one per cycle.
// Reset: aresetn is synchronous, active low; empties pipeline and result queue,
//   clears positions and pending run, threshold 0, row length and count 1024.
module zero_suppression_run_encoder_unit #(
    parameter int SAMPLE_BITS    = zsre_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_ROW_LENGTH = zsre_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROWS       = zsre_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zsre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [zsre_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [zsre_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // samples in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_BITS-1:0]            s_sample,
    // words out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_is_run,
    output logic [SAMPLE_BITS-1:0]            m_sample_value,
    output logic [zsre_pkg::RUN_OUT_W-1:0]    m_run_length,
    output logic [zsre_pkg::WORD_IDX_W-1:0]   m_word_index,
    output logic                              m_row_start,
    output logic                              m_frame_end,
    output logic                              m_last_for_item
);
    import zsre_pkg::*;

    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [CFG_LEN_W-1:0]   row_length_reg;
    logic [CFG_LEN_W-1:0]   row_count_reg;
    reg_idx_t               reg_idx;
    logic                   cfg_write;

    logic               room;
    logic [1:0]         push_cnt;
    word_t              push_word0, push_word1, head_word;
    logic [Q_CNT_W-1:0] level;

    // register file
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            row_length_reg <= ROW_LENGTH_RST;
            row_count_reg  <= ROW_COUNT_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_THRESHOLD:  threshold_reg  <= pwdata[THRESHOLD_W-1:0];
                REG_ROW_LENGTH: row_length_reg <= pwdata[CFG_LEN_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= pwdata[CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_reg);
            REG_ROW_LENGTH: prdata = APB_DATA_W'(row_length_reg);
            REG_ROW_COUNT:  prdata = APB_DATA_W'(row_count_reg);
            default:        prdata = '0;
        endcase
    end

    // datapath
    zsre_encoder #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_sample),
        .threshold  (threshold_reg),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .room       (room),
        .push_cnt   (push_cnt),
        .push_word0 (push_word0),
        .push_word1 (push_word1)
    );

    zsre_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_word0 (push_word0),
        .push_word1 (push_word1),
        .room       (room),
        .level      (level),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_word   (head_word)
    );

    // unpack head item
    assign m_is_run        = head_word.is_run;
    assign m_sample_value  = SAMPLE_BITS'(head_word.sample_value);
    assign m_run_length    = head_word.run_length;
    assign m_word_index    = head_word.word_index;
    assign m_row_start     = head_word.row_start;
    assign m_frame_end     = head_word.frame_end;
    assign m_last_for_item = head_word.last_for_item;

    // checks
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overfilled");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt == 2'd2 |-> push_word0.is_run && !push_word1.is_run
                             && push_word1.last_for_item && !push_word0.last_for_item)
        else $error("two-word item not run word then kept word");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_run |-> (m_run_length != '0) && (m_sample_value == '0))
        else $error("run word with empty run or sample value");

    a_kept_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_run |-> (m_run_length == '0) && m_last_for_item)
        else $error("kept word carries run length or is not last");

endmodule
